// File: design/fcpc_pkg.sv
// Shared types and constants of the four channel period capture block.
`default_nettype none
package fcpc_pkg;

   localparam int CHANNELS = 4;
   localparam int SLOTS    = 4;

   localparam logic [16:0] WRAP16      = 17'h10000;
   localparam logic [31:0] LOST_PERIOD = 32'hFFFF_FFFF;

   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_MIN_GLITCH = 2'd0,
      REG_LOCKOUT    = 2'd1,
      REG_MAX_OVF    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [15:0] min_glitch;
      logic [7:0]  lockout;
      logic [15:0] max_ovf;
   } cfg_type;

   typedef struct packed {
      logic        accept;
      op_type      op;
      logic        overflow;
      logic        capture;
      logic [15:0] value;
      logic        read_sel;
   } lane_cmd_type;

   typedef struct packed {
      logic        enable;
      logic        captured;
      logic [31:0] period;
      logic        ready;
      logic        seen;
      logic        present;
   } lane_stat_type;

endpackage
`default_nettype wire

// File: design/fcpc_lane.sv
// One capture channel: overflow, capture and status read update of its state.
`default_nettype none
module fcpc_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fcpc_pkg::lane_cmd_type cmd,
   input  wire fcpc_pkg::cfg_type      cfg,
   output fcpc_pkg::lane_stat_type     stat
);

   logic [15:0] stop_ff, stop_in;
   logic [15:0] ovf_cnt_ff, ovf_cnt_in;
   logic        present_ff, present_in;
   logic [7:0]  lock_cnt_ff, lock_cnt_in;
   logic        locked_ff, locked_in;
   logic        seen_ff, seen_in;
   logic [31:0] period_ff, period_in;
   logic        enable_ff, enable_in;

   logic        take;
   logic [15:0] gap;
   logic [15:0] ovf_less;
   logic [16:0] wrap_span;
   logic [31:0] period_sum;

   always_comb begin
      stop_in     = stop_ff;
      ovf_cnt_in  = ovf_cnt_ff;
      present_in  = present_ff;
      lock_cnt_in = lock_cnt_ff;
      locked_in   = locked_ff;
      seen_in     = seen_ff;
      period_in   = period_ff;
      enable_in   = enable_ff;
      take        = 1'b0;
      gap         = cmd.value - stop_ff;
      wrap_span   = fcpc_pkg::WRAP16 - {1'b0, stop_ff};
      ovf_less    = 16'd0;
      period_sum  = 32'd0;

      if (cmd.op == fcpc_pkg::OP_EVENT) begin
         // overflow is handled before the capture of the same event
         if (cmd.overflow) begin
            if (lock_cnt_ff != 8'd0) begin
               lock_cnt_in = lock_cnt_ff - 8'd1;
               if (lock_cnt_in == 8'd0) enable_in = 1'b1;
            end else begin
               if (present_ff) ovf_cnt_in = ovf_cnt_ff + 16'd1;
               if (ovf_cnt_in == cfg.max_ovf) begin
                  present_in = 1'b0;
                  ovf_cnt_in = 16'd0;
                  period_in  = fcpc_pkg::LOST_PERIOD;
               end
            end
         end

         take       = cmd.capture && enable_in;
         ovf_less   = ovf_cnt_in - 16'd1;
         period_sum = {ovf_less, 16'h0000} + {15'd0, wrap_span} + {16'd0, cmd.value};

         if (take) begin
            seen_in = 1'b1;
            stop_in = cmd.value;
            if (!present_in) begin
               present_in = 1'b1;
            end else if (ovf_cnt_in == 16'd0) begin
               if (gap < cfg.min_glitch) begin
                  enable_in   = 1'b0;
                  lock_cnt_in = cfg.lockout;
                  locked_in   = 1'b1;
               end else begin
                  period_in = {16'd0, gap};
               end
            end else begin
               period_in  = period_sum;
               ovf_cnt_in = 16'd0;
            end
         end
      end else if (cmd.read_sel) begin
         if (locked_ff && lock_cnt_ff == 8'd0) locked_in = 1'b0;
         seen_in = 1'b0;
      end

      stat.enable   = enable_in;
      stat.captured = take;
      stat.period   = period_ff;
      stat.ready    = !locked_ff;
      stat.seen     = seen_ff;
      stat.present  = present_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff     <= 16'd0;
         ovf_cnt_ff  <= 16'd0;
         present_ff  <= 1'b0;
         lock_cnt_ff <= 8'd0;
         locked_ff   <= 1'b0;
         seen_ff     <= 1'b0;
         period_ff   <= 32'd0;
         enable_ff   <= 1'b1;
      end else if (cmd.accept) begin
         stop_ff     <= stop_in;
         ovf_cnt_ff  <= ovf_cnt_in;
         present_ff  <= present_in;
         lock_cnt_ff <= lock_cnt_in;
         locked_ff   <= locked_in;
         seen_ff     <= seen_in;
         period_ff   <= period_in;
         enable_ff   <= enable_in;
      end
   end

endmodule
`default_nettype wire

// File: design/fcpc_merge.sv
// Merges lane status into one result and holds it in the output register.
`default_nettype none
module fcpc_merge (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire fcpc_pkg::op_type        op,
   input  wire logic                    overflow,
   input  wire logic [1:0]              channel,
   input  wire fcpc_pkg::lane_stat_type stat [fcpc_pkg::SLOTS],
   input  wire logic                    rsp_tready,
   output logic                         rsp_tvalid,
   output logic [39:0]                  rsp_tdata,
   output logic                         in_ready
);

   logic        valid_ff, valid_in;
   logic [39:0] data_ff, data_in;
   logic [3:0]  enables;
   logic        any;
   logic        spurious;
   fcpc_pkg::lane_stat_type pick;

   always_comb begin
      any = overflow;
      for (int i = 0; i < fcpc_pkg::SLOTS; i++) begin
         enables[i] = stat[i].enable;
         any        = any | stat[i].captured;
      end
      spurious = (op == fcpc_pkg::OP_EVENT) && !any;
      pick     = '0;
      if (op == fcpc_pkg::OP_READ) pick = stat[channel];
      data_in  = {pick.present, pick.seen, pick.ready, pick.period, spurious, enables};
      in_ready = !valid_ff || rsp_tready;
      valid_in = accept || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule
`default_nettype wire

// File: design/four_channel_period_capture.sv
// Top level: four lane period capture with configuration registers.
// A result is registered and valid in the cycle after its input transfer.
// Throughput: one item per cycle unless the input is stalled; each lane updates its state on every accepted item.
// The input is stalled only while a finished result waits unaccepted.
// Reset (synchronous): channel state cleared, all channels enabled,
// registers return to min_glitch_ticks 0, lockout_overflows 4, max_overflows 16.
`default_nettype none
module four_channel_period_capture (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // overflow, capture_flags, capture_value_0..3, channel, zero pad
   input  wire logic [71:0] req_tdata,
   // op
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // capture_enables, spurious, period_ticks, channel_ready, new_capture,
   // signal_present
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   fcpc_pkg::cfg_type       cfg_ff;
   fcpc_pkg::lane_stat_type stat [fcpc_pkg::SLOTS];
   fcpc_pkg::op_type        op;
   logic                    accept;
   logic                    in_ready;
   logic [1:0]              channel;

   assign csr_ready  = 1'b1;
   assign op         = fcpc_pkg::op_type'(req_tuser[0]);
   assign channel    = req_tdata[70:69];
   assign req_tready = in_ready;
   assign accept     = req_tvalid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_glitch <= 16'd0;
         cfg_ff.lockout    <= 8'd4;
         cfg_ff.max_ovf    <= 16'd16;
      end else if (csr_valid) begin
         case (fcpc_pkg::reg_index_type'(csr_index))
            fcpc_pkg::REG_MIN_GLITCH: cfg_ff.min_glitch <= csr_data;
            fcpc_pkg::REG_LOCKOUT:    cfg_ff.lockout    <= csr_data[7:0];
            fcpc_pkg::REG_MAX_OVF:    cfg_ff.max_ovf    <= csr_data;
            default: ;
         endcase
      end
   end

   for (genvar c = 0; c < fcpc_pkg::SLOTS; c++) begin : g_lane
      if (c < fcpc_pkg::CHANNELS) begin : g_live
         fcpc_pkg::lane_cmd_type cmd;
         always_comb begin
            cmd.accept   = accept;
            cmd.op       = op;
            cmd.overflow = req_tdata[0];
            cmd.capture  = req_tdata[1 + c];
            cmd.value    = req_tdata[5 + 16 * c +: 16];
            cmd.read_sel = (channel == 2'(c));
         end
         fcpc_lane u_lane (
            .clock (clock),
            .reset (reset),
            .cmd   (cmd),
            .cfg   (cfg_ff),
            .stat  (stat[c])
         );
      end else begin : g_absent
         assign stat[c] = '0;
      end
   end

   fcpc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (op),
      .overflow   (req_tdata[0]),
      .channel    (channel),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .in_ready   (in_ready)
   );

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with free output register");
   a_read_not_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0]) |=> !rsp_tdata[4])
      else $error("read transfer flagged spurious");
   a_overflow_not_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tuser[0] && req_tdata[0]) |=> !rsp_tdata[4])
      else $error("overflow event flagged spurious");
`endif

endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for the four channel period capture block: directed and random stream traffic.
`timescale 1ns / 100ps
module tb;
   import fcpc_pkg::*;

   typedef struct packed {
      op_type           op;
      logic             overflow;
      logic [3:0]       flags;
      logic [3:0][15:0] value;
      logic [1:0]       channel;
   } meter_item;

   // listed from the highest bit down, matching rsp_tdata
   typedef struct packed {
      logic        present;
      logic        fresh;
      logic        ready;
      logic [31:0] period;
      logic        spurious;
      logic [3:0]  enables;
   } meter_status;

   class period_meter_model;
      logic [15:0] min_glitch;
      logic [7:0]  lockout_len;
      logic [15:0] max_ovf;
      logic [15:0] start_pos [CHANNELS];
      logic [15:0] stop_pos [CHANNELS];
      logic [15:0] ovf_count [CHANNELS];
      logic [7:0]  lock_left [CHANNELS];
      logic [31:0] period [CHANNELS];
      bit          present [CHANNELS];
      bit          locked [CHANNELS];
      bit          seen [CHANNELS];
      bit          enabled [CHANNELS];
      meter_status pending [$];
      int          errors, items, reads, lockouts, losses, spans, checked;

      function new();
         min_glitch  = 16'd0;
         lockout_len = 8'd4;
         max_ovf     = 16'd16;
         for (int c = 0; c < CHANNELS; c++) begin
            start_pos[c] = '0;
            stop_pos[c]  = '0;
            ovf_count[c] = '0;
            lock_left[c] = '0;
            period[c]    = '0;
            present[c]   = 0;
            locked[c]    = 0;
            seen[c]      = 0;
            enabled[c]   = 1;
         end
      endfunction

      function void set_reg(reg_index_type idx, logic [15:0] val);
         case (idx)
            REG_MIN_GLITCH: min_glitch = val;
            REG_LOCKOUT:    lockout_len = val[7:0];
            REG_MAX_OVF:    max_ovf = val;
            default: ;
         endcase
      endfunction

      function void apply_item(meter_item it);
         meter_status s;
         bit          any;
         logic [15:0] gap;
         int          c;
         s = '0;
         any = 0;
         items++;
         if (it.op == OP_EVENT) begin
            if (it.overflow) begin
               any = 1;
               for (c = 0; c < CHANNELS; c++) begin
                  if (lock_left[c] >= 1) begin
                     lock_left[c]--;
                     if (lock_left[c] == 0) enabled[c] = 1;
                  end else begin
                     if (present[c]) ovf_count[c] = ovf_count[c] + 16'd1;
                     if (ovf_count[c] == max_ovf) begin
                        present[c]   = 0;
                        ovf_count[c] = '0;
                        period[c]    = LOST_PERIOD;
                        losses++;
                     end
                  end
               end
            end
            for (c = 0; c < CHANNELS; c++) begin
               if (it.flags[c] && enabled[c]) begin
                  any = 1;
                  seen[c] = 1;
                  if (!present[c]) begin
                     stop_pos[c] = it.value[c];
                     present[c]  = 1;
                  end else begin
                     start_pos[c] = stop_pos[c];
                     stop_pos[c]  = it.value[c];
                     if (ovf_count[c] == 0) begin
                        gap = stop_pos[c] - start_pos[c];
                        if (gap < min_glitch) begin
                           enabled[c]   = 0;
                           lock_left[c] = lockout_len;
                           locked[c]    = 1;
                           lockouts++;
                        end else
                           period[c] = {16'd0, gap};
                     end else begin
                        period[c] = (32'(WRAP16) - 32'(start_pos[c])) + 32'(stop_pos[c])
                                    + (32'(ovf_count[c]) - 32'd1) * 32'(WRAP16);
                        ovf_count[c] = '0;
                        spans++;
                     end
                  end
               end
            end
            s.spurious = !any;
         end else begin
            reads++;
            c = it.channel;
            if (c < CHANNELS) begin
               s.ready = !locked[c];
               if (locked[c] && lock_left[c] == 0) locked[c] = 0;
               s.period  = period[c];
               s.fresh   = seen[c];
               s.present = present[c];
               seen[c]   = 0;
            end
         end
         for (c = 0; c < CHANNELS; c++) s.enables[c] = enabled[c];
         pending.push_back(s);
      endfunction

      function void check_field(string name, logic [31:0] exp, logic [31:0] act);
         if (exp !== act) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            errors++;
         end
      endfunction

      function void compare_status(logic [39:0] d);
         meter_status e;
         meter_status a;
         if (pending.size() == 0) begin
            $error("result transfer with no outstanding item: %h", d);
            errors++;
            return;
         end
         e = pending.pop_front();
         a = d;
         checked++;
         check_field("capture_enables", 32'(e.enables), 32'(a.enables));
         check_field("spurious", 32'(e.spurious), 32'(a.spurious));
         check_field("period_ticks", e.period, a.period);
         check_field("channel_ready", 32'(e.ready), 32'(a.ready));
         check_field("new_capture", 32'(e.fresh), 32'(a.fresh));
         check_field("signal_present", 32'(e.present), 32'(a.present));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   period_meter_model meter = new();

   int          send_pct;
   int          stall_pct;
   int          ovf_pct;
   int          hold_left;
   int          phases;
   logic [15:0] cfg_glitch;
   logic [15:0] last_val [4];

   four_channel_period_capture DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: check transfers, then pick next tready
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) meter.compare_status(rsp_tdata);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic meter_item ev_item(bit ovf, logic [3:0] flags,
                                         logic [15:0] v0 = 0, logic [15:0] v1 = 0,
                                         logic [15:0] v2 = 0, logic [15:0] v3 = 0);
      meter_item it;
      it = '0;
      it.op       = OP_EVENT;
      it.overflow = ovf;
      it.flags    = flags;
      it.value    = {v3, v2, v1, v0};
      it.channel  = 2'($urandom);
      return it;
   endfunction

   function automatic meter_item rd_item(logic [1:0] ch);
      meter_item it;
      it = '0;
      it.op       = OP_READ;
      it.overflow = 1'($urandom);
      it.flags    = 4'($urandom);
      it.value    = 64'({$urandom, $urandom});
      it.channel  = ch;
      return it;
   endfunction

   // mostly plausible edge spacing per channel, with glitches, noise and status reads mixed in
   function automatic meter_item random_item();
      meter_item it;
      if ($urandom_range(99) < 15) return rd_item(2'($urandom));
      it = ev_item($urandom_range(99) < ovf_pct, '0);
      for (int c = 0; c < 4; c++) begin
         it.flags[c] = ($urandom_range(99) < 40);
         case ($urandom_range(9))
            0: it.value[c] = 16'($urandom);
            1: it.value[c] = last_val[c] + 16'($urandom_range(cfg_glitch));
            2: it.value[c] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: it.value[c] = last_val[c] + cfg_glitch + 16'($urandom_range(4000));
         endcase
         if (it.flags[c]) last_val[c] = it.value[c];
      end
      return it;
   endfunction

   task automatic send_item(input meter_item it);
      if (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, it.channel, it.value, it.flags, it.overflow};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      meter.apply_item(it);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      meter.set_reg(idx, val);
   endtask

   task automatic set_config(input logic [15:0] glitch, input logic [7:0] lockout,
                             input logic [15:0] max_ovf);
      req_tvalid <= 1'b0;
      while (meter.pending.size() != 0) @(posedge clock);
      write_reg(REG_MIN_GLITCH, glitch);
      write_reg(REG_LOCKOUT, {8'd0, lockout});
      write_reg(REG_MAX_OVF, max_ovf);
      csr_valid <= 1'b0;
      cfg_glitch = glitch;
   endtask

   task automatic run_phase(input logic [15:0] glitch, input logic [7:0] lockout,
                            input logic [15:0] max_ovf, input int send_idle,
                            input int recv_stall, input int ovf_rate, input int count,
                            input bit squeeze);
      set_config(glitch, lockout, max_ovf);
      send_pct  = send_idle;
      stall_pct = recv_stall;
      ovf_pct   = ovf_rate;
      phases++;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == count / 4) begin
            send_pct  = 0;
            hold_left = 300;
         end
         send_item(random_item());
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      send_pct   = 0;
      stall_pct  = 0;
      ovf_pct    = 25;
      hold_left  = 0;
      phases     = 0;
      cfg_glitch = '0;
      for (int c = 0; c < 4; c++) last_val[c] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: status at reset, first edges, glitch lockout, re-enable, loss, spans
      send_item(rd_item(2'd0));
      send_item(rd_item(2'd3));
      set_config(16'd100, 8'd1, 16'd2);
      send_item(ev_item(0, 4'h0));
      send_item(ev_item(0, 4'hF, 16'h0000, 16'hFFFF, 16'h1234, 16'hABCD));
      send_item(ev_item(0, 4'hF, 16'hFFFF, 16'h0000, 16'h1266, 16'hAFB5));
      send_item(ev_item(0, 4'h6, 16'h0000, 16'h0200, 16'h2000, 16'h0000));
      send_item(rd_item(2'd1));
      send_item(ev_item(1, 4'h3, 16'h0005, 16'h8000));
      send_item(rd_item(2'd1));
      send_item(rd_item(2'd1));
      send_item(ev_item(1, 4'h0));
      send_item(ev_item(1, 4'h0));
      send_item(rd_item(2'd0));
      send_item(rd_item(2'd2));
      send_item(ev_item(0, 4'h8, 16'h0, 16'h0, 16'h0, 16'hFFFF));
      send_item(ev_item(1, 4'h8, 16'h0, 16'h0, 16'h0, 16'h0010));
      send_item(rd_item(2'd3));
      set_config(16'd0, 8'd4, 16'd5);
      send_item(ev_item(0, 4'h1, 16'd100));
      send_item(ev_item(1, 4'h0));
      send_item(ev_item(1, 4'h0));
      send_item(ev_item(1, 4'h1, 16'd50));
      send_item(rd_item(2'd0));

      run_phase(16'd0, 8'd1, 16'd1, 0, 0, 30, 210, 0);
      run_phase(16'd65535, 8'd255, 16'd65535, 50, 0, 60, 210, 0);
      run_phase(16'd300, 8'd3, 16'd16, 0, 50, 20, 210, 0);
      run_phase(16'd1000, 8'd2, 16'd5, 9, 9, 25, 210, 0);
      run_phase(16'($urandom_range(2000)), 8'($urandom_range(1, 255)),
                16'($urandom_range(1, 65535)), 50, 50, 30, 210, 0);
      run_phase(16'd50, 8'd8, 16'd40, 0, 0, 25, 210, 1);

      req_tvalid <= 1'b0;
      while (meter.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Covered %0d items over %0d random phases, %0d status reads, %0d checked",
               meter.items, phases, meter.reads, meter.checked);
      $display("Saw %0d glitch lockouts, %0d signal losses, %0d periods spanning overflows",
               meter.lockouts, meter.losses, meter.spans);
      if (meter.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: files.f
design/fcpc_pkg.sv
design/fcpc_lane.sv
design/fcpc_merge.sv
design/four_channel_period_capture.sv
dv/tb.sv
